[hdl/btpc_pkg.sv]
// Shared types and constants for the barometer compensation pipeline.
`default_nettype none

package btpc_pkg;

    localparam int RAW_W      = 24;
    localparam int CFG_DATA_W = 48;
    localparam int TEMP_OUT_W = 15;
    localparam int PRES_OUT_W = 17;
    localparam int TQ_W       = 20;
    localparam int SUM_W      = 48;
    localparam int CENTI_W    = 24;

    // Register stages in each half of the datapath.
    localparam int TEMP_LAT  = 5;
    localparam int PRESS_LAT = 6;
    localparam int PIPE_LAT  = TEMP_LAT + PRESS_LAT;

    typedef enum logic [1:0] {
        CFG_TEMP_TRIM    = 2'd0,
        CFG_PRESS_TRIM_A = 2'd1,
        CFG_PRESS_TRIM_B = 2'd2,
        CFG_PRESS_TRIM_C = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        t1;
        logic [15:0]        t2;
        logic signed [7:0]  t3;
    } t_temp_trim;

    typedef struct packed {
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } t_press_trim;

    // Rounding offsets for the Q48 temperature word.
    localparam logic signed [63:0] TN_HALF_Q16 = 64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] TN_HALF_Q12 = 64'sh0000_0008_0000_0000;

    // Pressure-path temperature clamp, Q12 degC.
    localparam logic signed [TQ_W-1:0] TQ_MIN = -20'sd163840;
    localparam logic signed [TQ_W-1:0] TQ_MAX = 20'sd348160;

    localparam logic signed [CENTI_W-1:0] CENTI_MIN = -24'sd4000;
    localparam logic signed [CENTI_W-1:0] CENTI_MAX = 24'sd8500;

    localparam logic signed [31:0] PA_MAX = 32'sd131071;

    localparam logic signed [16:0] COEF_OFFSET = 17'sd16384;

endpackage

`default_nettype wire

[hdl/baro_temp_pressure_compensation.sv]
// Top level of the barometer compensation pipeline with trim registers.
// One request (raw temperature and raw pressure) is accepted per clock while
// o_ready is high; the result passes through the 11 arithmetic register stages
// (5 for temperature, 6 for pressure) and then the output register. The whole
// pipeline advances together and holds while a finished result is not taken,
// so o_ready falls only when the output register is full and not being read.
// Trim words are written through the write port and should be changed only
// while no request is in flight.
`default_nettype none

module baro_temp_pressure_compensation (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire [btpc_pkg::RAW_W-1:0]             i_raw_temperature,
    input  wire [btpc_pkg::RAW_W-1:0]             i_raw_pressure,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic signed [btpc_pkg::TEMP_OUT_W-1:0] o_comp_temperature,
    output logic [btpc_pkg::PRES_OUT_W-1:0]       o_comp_pressure,
    output logic                                  o_out_of_range,
    input  wire                                   i_cfg_we,
    input  wire [1:0]                             i_cfg_index,
    input  wire [btpc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import btpc_pkg::*;

    logic [39:0] r_temp_trim;
    logic [47:0] r_press_trim_a;
    logic [47:0] r_press_trim_b;
    logic [31:0] r_press_trim_c;

    t_temp_trim  temp_trim;
    t_press_trim press_trim;

    logic                   en;
    logic [PIPE_LAT-1:0]    r_vld;
    logic [RAW_W-1:0]       r_up_dly [TEMP_LAT];
    logic signed [TEMP_OUT_W-1:0] r_centi_dly [PRESS_LAT];
    logic                   r_clip_dly [PRESS_LAT];

    logic signed [TEMP_OUT_W-1:0] centi;
    logic                   tclip;
    logic signed [TQ_W-1:0] tq;
    logic signed [SUM_W-1:0] sum;

    logic signed [31:0]     n_pa_w;
    logic [PRES_OUT_W-1:0]  n_pa;
    logic                   n_pclip;

    logic                   r_out_valid;
    logic signed [TEMP_OUT_W-1:0] r_out_temp;
    logic [PRES_OUT_W-1:0]  r_out_press;
    logic                   r_out_flag;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    // The register packs T1 in the low bits; the struct lists T1 first (high bits).
    assign temp_trim  = t_temp_trim'({r_temp_trim[15:0], r_temp_trim[31:16],
                                      r_temp_trim[39:32]});
    assign press_trim = t_press_trim'({r_press_trim_a[15:0], r_press_trim_a[31:16],
                                       r_press_trim_a[39:32], r_press_trim_a[47:40],
                                       r_press_trim_b[15:0], r_press_trim_b[31:16],
                                       r_press_trim_b[39:32], r_press_trim_b[47:40],
                                       r_press_trim_c[15:0], r_press_trim_c[23:16],
                                       r_press_trim_c[31:24]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim    <= '0;
            r_press_trim_a <= '0;
            r_press_trim_b <= '0;
            r_press_trim_c <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_TRIM:    r_temp_trim    <= i_cfg_data[39:0];
                CFG_PRESS_TRIM_A: r_press_trim_a <= i_cfg_data;
                CFG_PRESS_TRIM_B: r_press_trim_b <= i_cfg_data;
                CFG_PRESS_TRIM_C: r_press_trim_c <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    btpc_temp u_temp (
        .i_clk             (i_clk),
        .i_en              (en),
        .i_raw_temperature (i_raw_temperature),
        .i_trim            (temp_trim),
        .o_centi           (centi),
        .o_clip            (tclip),
        .o_tq              (tq)
    );

    btpc_press u_press (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_tq           (tq),
        .i_raw_pressure (r_up_dly[TEMP_LAT-1]),
        .i_trim         (press_trim),
        .o_sum          (sum)
    );

    // Raw pressure waits for the temperature stages; temperature results wait
    // for the pressure stages.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_up_dly[0] <= i_raw_pressure;
            for (int i = 1; i < TEMP_LAT; i++) begin
                r_up_dly[i] <= r_up_dly[i-1];
            end
            r_centi_dly[0] <= centi;
            r_clip_dly[0]  <= tclip;
            for (int i = 1; i < PRESS_LAT; i++) begin
                r_centi_dly[i] <= r_centi_dly[i-1];
                r_clip_dly[i]  <= r_clip_dly[i-1];
            end
        end
    end

    assign n_pa_w = 32'((sum + 48'sd32768) >>> 16);

    always_comb begin
        if (n_pa_w < 32'sd0) begin
            n_pa    = '0;
            n_pclip = 1'b1;
        end else if (n_pa_w > PA_MAX) begin
            n_pa    = PRES_OUT_W'(PA_MAX);
            n_pclip = 1'b1;
        end else begin
            n_pa    = PRES_OUT_W'(n_pa_w);
            n_pclip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[PIPE_LAT-2:0], i_valid};
            r_out_valid <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_temp  <= r_centi_dly[PRESS_LAT-1];
            r_out_press <= n_pa;
            r_out_flag  <= r_clip_dly[PRESS_LAT-1] | n_pclip;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_comp_temperature = r_out_temp;
    assign o_comp_pressure    = r_out_press;
    assign o_out_of_range     = r_out_flag;

endmodule

`default_nettype wire

[hdl/btpc_temp.sv]
// Temperature half of the pipeline: quadratic linearization and rounding.
`default_nettype none

module btpc_temp (
    input  wire                               i_clk,
    input  wire                               i_en,
    input  wire [btpc_pkg::RAW_W-1:0]         i_raw_temperature,
    input  btpc_pkg::t_temp_trim              i_trim,
    output logic signed [btpc_pkg::TEMP_OUT_W-1:0] o_centi,
    output logic                              o_clip,
    output logic signed [btpc_pkg::TQ_W-1:0]  o_tq
);
    import btpc_pkg::*;

    logic signed [25:0]         n_d;
    logic signed [25:0]         r_d;
    logic signed [42:0]         r_a;
    logic signed [51:0]         r_dd;
    logic signed [63:0]         n_tn;
    logic signed [63:0]         r_tn;
    logic signed [31:0]         r_t16;
    logic signed [27:0]         n_tqw;
    logic signed [TQ_W-1:0]     n_tq;
    logic signed [TQ_W-1:0]     r_tq;
    logic signed [39:0]         n_cw;
    logic signed [CENTI_W-1:0]  n_c24;
    logic signed [TEMP_OUT_W-1:0] r_centi;
    logic                       r_clip;
    logic signed [TQ_W-1:0]     r_tq5;
    logic signed [TEMP_OUT_W-1:0] n_centi;
    logic                       n_clip;

    assign n_d = $signed({2'b00, i_raw_temperature}) - $signed({2'b00, i_trim.t1, 8'h00});

    // Temperature in degC scaled by 2^48, held exactly.
    assign n_tn = (64'(r_a) <<< 18) + 64'(r_dd) * 64'(i_trim.t3);

    assign n_tqw = 28'((r_tn + TN_HALF_Q12) >>> 36);

    always_comb begin
        if (n_tqw < 28'(TQ_MIN)) begin
            n_tq = TQ_MIN;
        end else if (n_tqw > 28'(TQ_MAX)) begin
            n_tq = TQ_MAX;
        end else begin
            n_tq = TQ_W'(n_tqw);
        end
    end

    assign n_cw  = 40'(r_t16) * 40'sd100 + 40'sd32768;
    assign n_c24 = CENTI_W'(n_cw >>> 16);

    always_comb begin
        if (n_c24 < CENTI_MIN) begin
            n_centi = TEMP_OUT_W'(CENTI_MIN);
            n_clip  = 1'b1;
        end else if (n_c24 > CENTI_MAX) begin
            n_centi = TEMP_OUT_W'(CENTI_MAX);
            n_clip  = 1'b1;
        end else begin
            n_centi = TEMP_OUT_W'(n_c24);
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d     <= n_d;
            r_a     <= r_d * $signed({1'b0, i_trim.t2});
            r_dd    <= r_d * r_d;
            r_tn    <= n_tn;
            r_t16   <= 32'((r_tn + TN_HALF_Q16) >>> 32);
            r_tq    <= n_tq;
            r_centi <= n_centi;
            r_clip  <= n_clip;
            r_tq5   <= r_tq;
        end
    end

    assign o_centi = r_centi;
    assign o_clip  = r_clip;
    assign o_tq    = r_tq5;

endmodule

`default_nettype wire

[hdl/btpc_press.sv]
// Pressure half of the pipeline: trim polynomial summed in Q16 pascal.
`default_nettype none

module btpc_press (
    input  wire                               i_clk,
    input  wire                               i_en,
    input  wire signed [btpc_pkg::TQ_W-1:0]   i_tq,
    input  wire [btpc_pkg::RAW_W-1:0]         i_raw_pressure,
    input  btpc_pkg::t_press_trim             i_trim,
    output logic signed [btpc_pkg::SUM_W-1:0] o_sum
);
    import btpc_pkg::*;

    logic signed [16:0] p1m;
    logic signed [16:0] p2m;

    logic signed [TQ_W-1:0] r1_tq;
    logic [RAW_W-1:0]       r1_up;
    logic signed [39:0]     r1_tq2;
    logic signed [36:0]     r1_p6tq;
    logic signed [36:0]     r1_p2tq;
    logic signed [27:0]     r1_p10tq;

    logic [RAW_W-1:0]       r2_up;
    logic signed [59:0]     r2_tq3;
    logic signed [47:0]     r2_p7tq2;
    logic signed [47:0]     r2_p3tq2;
    logic signed [28:0]     r2_u;
    logic [47:0]            r2_upsq;
    logic signed [36:0]     r2_p6tq;
    logic signed [36:0]     r2_p2tq;

    logic [RAW_W-1:0]       r3_up;
    logic signed [67:0]     r3_p8tq3;
    logic signed [67:0]     r3_p4tq3;
    logic signed [53:0]     r3_upu;
    logic signed [56:0]     r3_n0;
    logic signed [36:0]     r3_p6tq;
    logic signed [36:0]     r3_p2tq;
    logic signed [47:0]     r3_p7tq2;
    logic signed [47:0]     r3_p3tq2;

    logic signed [39:0]     n_sens;
    logic signed [39:0]     n_suma;
    logic [RAW_W-1:0]       r4_up;
    logic signed [39:0]     r4_sens;
    logic signed [39:0]     r4_suma;
    logic signed [33:0]     r4_m;
    logic signed [31:0]     r4_n;

    logic signed [64:0]     r5_upsens;
    logic signed [58:0]     r5_mup;
    logic signed [56:0]     r5_nup;
    logic signed [39:0]     r5_suma;

    logic signed [SUM_W-1:0] r6_sum;

    assign p1m = 17'(i_trim.p1) - COEF_OFFSET;
    assign p2m = 17'(i_trim.p2) - COEF_OFFSET;

    // Sensitivity coefficient in Q40, offset part in Q16.
    assign n_sens = (40'(p1m) <<< 20) + 40'(r3_p2tq >>> 1)
                  + 40'(r3_p3tq2 >>> 16) + 40'(r3_p4tq3 >>> 33);
    assign n_suma = (40'($signed({1'b0, i_trim.p5})) <<< 19) + 40'(r3_p6tq >>> 2)
                  + 40'(r3_p7tq2 >>> 16) + 40'(r3_p8tq3 >>> 35);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tq     <= i_tq;
            r1_up     <= i_raw_pressure;
            r1_tq2    <= i_tq * i_tq;
            r1_p6tq   <= $signed({1'b0, i_trim.p6}) * i_tq;
            r1_p2tq   <= p2m * i_tq;
            r1_p10tq  <= i_trim.p10 * i_tq;

            r2_up     <= r1_up;
            r2_tq3    <= r1_tq2 * r1_tq;
            r2_p7tq2  <= i_trim.p7 * r1_tq2;
            r2_p3tq2  <= i_trim.p3 * r1_tq2;
            r2_u      <= (29'(i_trim.p9) <<< 12) + 29'(r1_p10tq);
            r2_upsq   <= r1_up * r1_up;
            r2_p6tq   <= r1_p6tq;
            r2_p2tq   <= r1_p2tq;

            r3_up     <= r2_up;
            r3_p8tq3  <= i_trim.p8 * r2_tq3;
            r3_p4tq3  <= i_trim.p4 * r2_tq3;
            r3_upu    <= $signed({1'b0, r2_up}) * r2_u;
            r3_n0     <= $signed({1'b0, r2_upsq}) * i_trim.p11;
            r3_p6tq   <= r2_p6tq;
            r3_p2tq   <= r2_p2tq;
            r3_p7tq2  <= r2_p7tq2;
            r3_p3tq2  <= r2_p3tq2;

            r4_up     <= r3_up;
            r4_sens   <= n_sens;
            r4_suma   <= n_suma;
            r4_m      <= 34'(r3_upu >>> 20);
            r4_n      <= 32'(r3_n0 >>> 25);

            r5_upsens <= $signed({1'b0, r4_up}) * r4_sens;
            r5_mup    <= r4_m * $signed({1'b0, r4_up});
            r5_nup    <= r4_n * $signed({1'b0, r4_up});
            r5_suma   <= r4_suma;

            r6_sum    <= SUM_W'(r5_suma) + SUM_W'(r5_upsens >>> 24)
                       + SUM_W'(r5_mup >>> 24) + SUM_W'(r5_nup >>> 24);
        end
    end

    assign o_sum = r6_sum;

endmodule

`default_nettype wire

[hdl/btpc_checker.sv]
// Port-level checks for the barometer compensation top level.
`default_nettype none

module btpc_checker (
    input wire                                    i_clk,
    input wire                                    i_rst_n,
    input wire                                    o_ready,
    input wire                                    o_valid,
    input wire                                    i_ready,
    input wire signed [btpc_pkg::TEMP_OUT_W-1:0]  o_comp_temperature,
    input wire [btpc_pkg::PRES_OUT_W-1:0]         o_comp_pressure,
    input wire                                    o_out_of_range
);
    import btpc_pkg::*;

    // A held result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_comp_temperature)
            && $stable(o_comp_pressure) && $stable(o_out_of_range))
        else $error("result changed while stalled");

    // The pipeline stops taking requests only when the output is blocked.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("request refused without an output stall");

    a_trange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_comp_temperature >= 15'(CENTI_MIN)
            && o_comp_temperature <= 15'(CENTI_MAX))
        else $error("temperature outside saturation limits");

    // A clipped result always sits on one of the limits.
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_comp_temperature == 15'(CENTI_MIN)
            || o_comp_temperature == 15'(CENTI_MAX)
            || o_comp_pressure == '0 || o_comp_pressure == 17'(PA_MAX))
        else $error("range flag set on an unclipped result");

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_comp_temperature (o_comp_temperature),
    .o_comp_pressure    (o_comp_pressure),
    .o_out_of_range     (o_out_of_range)
);

`default_nettype wire
